@@ rtl/core/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, constants and window helpers for the isolated star counter.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_COLS_DEF = 128;

    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int TOTAL_W     = 13;
    localparam int HITS_W      = 3;
    localparam int LS_W        = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // Per-pixel control from the position counters to the window unit.
    typedef struct packed {
        logic accept;
        logic first_col;
        logic last_col;
        logic last_row;
        logic has_above;
    } t_win_ctl;

    // Center bit set and no other in-frame bit set in the 3x3 neighborhood.
    // Columns l, m, r hold rows in bit order r, r-1, r-2.
    function automatic logic lone(input logic [2:0] l,
                                  input logic [2:0] m,
                                  input logic [2:0] r,
                                  input logic       cbit,
                                  input logic [2:0] mask);
        logic [2:0] cb;
        cb = cbit ? 3'b010 : 3'b001;
        return ((m & cb) != 3'b000) &&
               (((l & mask) | (m & mask & ~cb) | (r & mask)) == 3'b000);
    endfunction

endpackage

@@ rtl/core/isc_ram.sv @@
// ----------------------------------------------------------------------------
// isc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/isc_window.sv @@
// ----------------------------------------------------------------------------
// isc_window
// 3x3 window over the current pixel and two stored rows; decides the cells
// whose neighborhood is complete and returns the number of isolated hits.
// ----------------------------------------------------------------------------
module isc_window (
    input  logic                        i_clk,
    input  isc_pkg::t_win_ctl           i_ctl,
    input  logic [isc_pkg::LS_W-1:0]    i_ls,
    input  logic                        i_pix,
    output logic [isc_pkg::HITS_W-1:0]  o_hits
);
    import isc_pkg::*;

    // only the two newest columns carry over to the next pixel
    logic [5:0] r_win;
    logic [8:0] n_win;
    logic [2:0] trip;
    logic [2:0] w0;
    logic [2:0] w1;
    logic [2:0] w2;
    logic       h0;
    logic       h1;
    logic       h2;
    logic       h3;

    assign trip = {i_ls, i_pix};

    // First column starts a fresh window; otherwise shift one column left.
    assign n_win = i_ctl.first_col ? {trip, 6'b0} : {trip, r_win};
    assign w0 = n_win[2:0];
    assign w1 = n_win[5:3];
    assign w2 = n_win[8:6];

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_win <= n_win[8:3];
        end
    end

    // Row above the current one, then the current row on the last row.
    assign h0 = i_ctl.has_above & ~i_ctl.first_col & lone(w0, w1, w2, 1'b1, 3'b111);
    assign h1 = i_ctl.has_above & i_ctl.last_col   & lone(w1, w2, 3'b000, 1'b1, 3'b111);
    assign h2 = i_ctl.last_row  & ~i_ctl.first_col & lone(w0, w1, w2, 1'b0, 3'b011);
    assign h3 = i_ctl.last_row  & i_ctl.last_col   & lone(w1, w2, 3'b000, 1'b0, 3'b011);

    assign o_hits = HITS_W'(h0) + HITS_W'(h1) + HITS_W'(h2) + HITS_W'(h3);

endmodule

@@ rtl/core/isolated_star_counter.sv @@
// ----------------------------------------------------------------------------
// isolated_star_counter
// Counts stars with no star among their eight neighbors in a raster frame.
// ----------------------------------------------------------------------------
// Pixels enter one per cycle in raster order, one transfer per clock when the
// output side keeps up; a frame's count leaves as one transfer on its last
// pixel. The two previous rows live in a line RAM with registered read data,
// read ahead at the next column address; a bypass covers single-column
// frames where read and write hit the same entry. Stored rows are ignored
// on row zero, so no clearing pass is needed after reset, after a frame or
// after a register write. A register write restarts the frame. Dimension
// values of zero act as one, values above the maximum as the maximum. The
// count saturates at 8191.
module isolated_star_counter #(
    parameter int MAX_ROWS = isc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = isc_pkg::MAX_COLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [isc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [isc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [isc_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [0] is_star
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [isc_pkg::OUT_TDATA_W-1:0]  o_m_tdata    // [12:0] isolated_total
);
    import isc_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EWR = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int EWC = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    logic [CFG_W-1:0]   r_row_count;
    logic [CFG_W-1:0]   r_col_count;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      n_col;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_data;
    logic               r_byp;
    logic [LS_W-1:0]    r_byp_data;

    logic [EWR-1:0]     rows_eff;
    logic [EWC-1:0]     cols_eff;
    logic               accept;
    logic               last_row;
    logic               last_col;
    logic [LS_W-1:0]    rd_data;
    logic [LS_W-1:0]    ls;
    logic [LS_W-1:0]    wr_data;
    logic [HITS_W-1:0]  hits;
    logic [TOTAL_W:0]   sum;
    t_win_ctl           win_ctl;

    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = EWR'(1);
        end else if (EWR'(r_row_count) > EWR'(MAX_ROWS)) begin
            rows_eff = EWR'(MAX_ROWS);
        end else begin
            rows_eff = EWR'(r_row_count);
        end
        if (r_col_count == '0) begin
            cols_eff = EWC'(1);
        end else if (EWC'(r_col_count) > EWC'(MAX_COLS)) begin
            cols_eff = EWC'(MAX_COLS);
        end else begin
            cols_eff = EWC'(r_col_count);
        end
    end

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign accept     = i_s_tvalid & o_s_tready;
    assign last_row   = (EWR'(r_row) + EWR'(1)) >= rows_eff;
    assign last_col   = (EWC'(r_col) + EWC'(1)) >= cols_eff;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cfg_we) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // Line RAM: read at the next column so data is ready for the next pixel.
    isc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (wr_data),
        .i_raddr (n_col),
        .o_rdata (rd_data)
    );

    // Row zero sees empty rows above, whatever the RAM holds.
    assign ls      = (r_row == '0) ? '0 : (r_byp ? r_byp_data : rd_data);
    assign wr_data = {ls[0], i_s_tdata[0]};

    always_ff @(posedge i_clk) begin
        r_byp      <= accept && (r_col == n_col);
        r_byp_data <= wr_data;
    end

    assign win_ctl = '{accept:    accept,
                       first_col: (r_col == '0),
                       last_col:  last_col,
                       last_row:  last_row,
                       has_above: (r_row != '0)};

    isc_window u_window (
        .i_clk  (i_clk),
        .i_ctl  (win_ctl),
        .i_ls   (ls),
        .i_pix  (i_s_tdata[0]),
        .o_hits (hits)
    );

    assign sum     = {1'b0, r_total} + (TOTAL_W + 1)'(hits);
    assign n_total = (sum > (TOTAL_W + 1)'(TOTAL_LIMIT)) ? TOTAL_LIMIT : sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_W'(1);
            r_col_count <= CFG_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_COUNT: r_row_count <= i_cfg_data;
                    REG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
                r_total <= '0;
            end else if (accept) begin
                r_total <= (last_row && last_col) ? '0 : n_total;
            end
            if (accept && last_row && last_col) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last_row && last_col) begin
            r_out_data <= n_total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_data);

endmodule
